@@ sv/olt_pkg.sv @@
// ---------------------------------------------------------------------------
// olt_pkg - shared types and constants of the order lifecycle table
// Command, order state, status and send codes, the table entry layout and
// the result record carried from lookup to the output register.
// ---------------------------------------------------------------------------
package olt_pkg;

   // table size and derived widths
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int NID_W       = $clog2(TABLE_DEPTH + 1);

   // fixed field widths
   localparam int CMD_W   = 3;
   localparam int ID_W    = 10;
   localparam int WORD_W  = 64;
   localparam int QTY_W   = 32;
   localparam int RISK_W  = 4;
   localparam int STAT_W  = 3;
   localparam int OST_W   = 3;
   localparam int SEND_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE     = 3'd0,
      CMD_ACK_CREATE = 3'd1,
      CMD_FILL       = 3'd2,
      CMD_CANCEL     = 3'd3,
      CMD_ACK_CANCEL = 3'd4,
      CMD_QUERY      = 3'd5
   } cmd_type;

   typedef enum logic [OST_W-1:0] {
      OS_UNKNOWN   = 3'd0,
      OS_PENDING   = 3'd1,
      OS_LIVE      = 3'd2,
      OS_PARTIAL   = 3'd3,
      OS_FILLED    = 3'd4,
      OS_PCANCEL   = 3'd5,
      OS_CANCELLED = 3'd6,
      OS_REJECTED  = 3'd7
   } ostate_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK            = 3'd0,
      STAT_TABLE_FULL    = 3'd1,
      STAT_INVALID_ID    = 3'd2,
      STAT_NOT_FILLABLE  = 3'd3,
      STAT_OVERFILL      = 3'd4,
      STAT_RISK_REJECTED = 3'd5,
      STAT_CANCEL_IGNORE = 3'd6
   } status_type;

   typedef enum logic [SEND_W-1:0] {
      SEND_NONE   = 2'd0,
      SEND_CREATE = 2'd1,
      SEND_CANCEL = 2'd2,
      SEND_FILL   = 2'd3
   } send_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_FINISH
   } fsm_type;

   // one table entry, kept as a single memory word
   typedef struct packed {
      logic [WORD_W-1:0] price;
      logic [QTY_W-1:0]  qty;
      logic [QTY_W-1:0]  filled;
      logic              side;
      ostate_type        state;
   } entry_type;

   // one result item
   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   result_id;
      ostate_type        order_state;
      send_type          send_kind;
      logic [WORD_W-1:0] out_timestamp;
      logic [WORD_W-1:0] out_price;
      logic [QTY_W-1:0]  out_qty;
      logic              out_side;
      logic [QTY_W-1:0]  filled_total;
      logic [RISK_W-1:0] risk_echo;
      logic [WORD_W-1:0] holdings_now;
      logic [WORD_W-1:0] cash_now;
   } result_type;

endpackage

@@ sv/order_lifecycle_table.sv @@
// ---------------------------------------------------------------------------
// order_lifecycle_table - trading order table
// Keeps up to TABLE_DEPTH orders in one synchronous memory and applies one
// command per item with a read-modify-write of the addressed entry, plus the
// net position and cash balance registers.
// ---------------------------------------------------------------------------
// Each item is read from memory on acceptance, decided and written back in the
// lookup state and loaded into the result register from the finish state; the
// next item is taken on the finish cycle, while the last result is loaded.
// A stalled result holds up acceptance only when a further result is ready.
// Reset clears the id counter, position, cash and control; the table memory
// is not cleared, as only entries already created are used.
module order_lifecycle_table (
   input  logic                         clock,
   input  logic                         reset,
   // input channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [olt_pkg::CMD_W-1:0]    req_command,
   input  logic [olt_pkg::WORD_W-1:0]   req_event_ts,
   input  logic [olt_pkg::ID_W-1:0]     req_oid,
   input  logic signed [olt_pkg::WORD_W-1:0] req_price,
   input  logic [olt_pkg::QTY_W-1:0]    req_qty,
   input  logic                         req_side,
   input  logic [olt_pkg::RISK_W-1:0]   req_risk_code,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [olt_pkg::STAT_W-1:0]   rsp_status,
   output logic [olt_pkg::ID_W-1:0]     rsp_result_id,
   output logic [olt_pkg::OST_W-1:0]    rsp_order_state,
   output logic [olt_pkg::SEND_W-1:0]   rsp_send_kind,
   output logic [olt_pkg::WORD_W-1:0]   rsp_out_timestamp,
   output logic signed [olt_pkg::WORD_W-1:0] rsp_out_price,
   output logic [olt_pkg::QTY_W-1:0]    rsp_out_qty,
   output logic                         rsp_out_side,
   output logic [olt_pkg::QTY_W-1:0]    rsp_filled_total,
   output logic [olt_pkg::RISK_W-1:0]   rsp_risk_echo,
   output logic signed [olt_pkg::WORD_W-1:0] rsp_holdings_now,
   output logic signed [olt_pkg::WORD_W-1:0] rsp_cash_now
);
   import olt_pkg::*;

   // control
   fsm_type            state_ff, state_in;
   logic               accept, out_free, lookup_en, finish_go;
   logic               rsp_valid_ff;

   // captured item
   logic [CMD_W-1:0]   cmd_ff;
   logic [WORD_W-1:0]  ts_ff;
   logic [ID_W-1:0]    id_ff;
   logic [WORD_W-1:0]  price_ff;
   logic [QTY_W-1:0]   qty_ff;
   logic               side_ff;
   logic [RISK_W-1:0]  risk_ff;

   // fill product, two partial products then their sum
   logic [WORD_W-1:0]  prod_lo_in, prod_lo_ff;
   logic [QTY_W-1:0]   prod_hi_in, prod_hi_ff;
   logic [WORD_W-1:0]  prod_ff;

   // table memory
   entry_type          table_mem [TABLE_DEPTH];
   entry_type          rd_ff;
   entry_type          wdata;
   logic [IDX_W-1:0]   waddr;
   logic               wr_en;

   // architectural registers
   logic [NID_W-1:0]   next_id_ff;
   logic               nid_inc;
   logic [WORD_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0]  cash_ff, cash_in;

   // lookup results
   result_type         res, wk_ff, rsp_ff, rsp_in;
   logic               do_fill, do_fill_ff, fill_side_ff;
   logic               id_ok;
   logic [QTY_W-1:0]   remaining, new_filled;

   // ---------------- state machine ----------------
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) state_in = FSM_LOOKUP;
         end
         FSM_LOOKUP: begin
            state_in = FSM_FINISH;
         end
         FSM_FINISH: begin
            if (out_free) state_in = accept ? FSM_LOOKUP : FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      lookup_en = 1'b0;
      finish_go = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
         end
         FSM_LOOKUP: begin
            lookup_en = 1'b1;
         end
         FSM_FINISH: begin
            finish_go = out_free;
            req_stall = !out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- item capture and partial products ----------------
   assign prod_lo_in = req_qty * req_price[QTY_W-1:0];
   assign prod_hi_in = req_qty * req_price[WORD_W-1:QTY_W];

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_command;
         ts_ff      <= req_event_ts;
         id_ff      <= req_oid;
         price_ff   <= req_price;
         qty_ff     <= req_qty;
         side_ff    <= req_side;
         risk_ff    <= req_risk_code;
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
   end

   // ---------------- table memory ----------------
   // read on acceptance, data ready in the lookup cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= table_mem[IDX_W'(req_oid)];
      end
   end

   // write back in the lookup cycle; no read shares that edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[waddr] <= wdata;
      end
   end

   // ---------------- lookup: decide and modify ----------------
   always_comb begin
      res            = '0;
      res.result_id  = id_ff;
      wdata          = rd_ff;
      waddr          = IDX_W'(id_ff);
      wr_en          = 1'b0;
      nid_inc        = 1'b0;
      do_fill        = 1'b0;
      id_ok          = NID_W'(id_ff) < next_id_ff;
      remaining      = rd_ff.qty - rd_ff.filled;
      new_filled     = rd_ff.filled + qty_ff;

      case (cmd_ff)
         CMD_CREATE: begin
            res.result_id = '0;
            res.risk_echo = risk_ff;
            if (next_id_ff >= NID_W'(TABLE_DEPTH)) begin
               res.status = STAT_TABLE_FULL;
            end else begin
               nid_inc       = 1'b1;
               wr_en         = lookup_en;
               waddr         = IDX_W'(next_id_ff);
               wdata.price   = price_ff;
               wdata.qty     = qty_ff;
               wdata.filled  = '0;
               wdata.side    = side_ff;
               res.result_id = ID_W'(next_id_ff);
               if (risk_ff != '0) begin
                  wdata.state     = OS_REJECTED;
                  res.status      = STAT_RISK_REJECTED;
                  res.order_state = OS_REJECTED;
               end else begin
                  wdata.state       = OS_PENDING;
                  res.order_state   = OS_PENDING;
                  res.send_kind     = SEND_CREATE;
                  res.out_timestamp = ts_ff;
                  res.out_price     = price_ff;
                  res.out_qty       = qty_ff;
                  res.out_side      = side_ff;
               end
            end
         end
         CMD_ACK_CREATE, CMD_FILL, CMD_CANCEL, CMD_ACK_CANCEL, CMD_QUERY: begin
            if (!id_ok) begin
               res.status = STAT_INVALID_ID;
            end else begin
               case (cmd_ff)
                  CMD_ACK_CREATE: begin
                     wdata.state = OS_LIVE;
                     wr_en       = lookup_en;
                  end
                  CMD_FILL: begin
                     if (!(rd_ff.state inside {OS_LIVE, OS_PARTIAL, OS_PCANCEL})) begin
                        res.status = STAT_NOT_FILLABLE;
                     end else if (qty_ff > remaining) begin
                        res.status = STAT_OVERFILL;
                     end else begin
                        do_fill       = 1'b1;
                        wr_en         = lookup_en;
                        wdata.filled  = new_filled;
                        wdata.state   = (new_filled == rd_ff.qty) ? OS_FILLED : OS_PARTIAL;
                        res.send_kind = SEND_FILL;
                        res.out_price = price_ff;
                        res.out_qty   = qty_ff;
                        res.out_side  = rd_ff.side;
                     end
                  end
                  CMD_CANCEL: begin
                     if (rd_ff.state inside {OS_FILLED, OS_PCANCEL, OS_CANCELLED}) begin
                        res.status = STAT_CANCEL_IGNORE;
                     end else begin
                        wdata.state       = OS_PCANCEL;
                        wr_en             = lookup_en;
                        res.send_kind     = SEND_CANCEL;
                        res.out_timestamp = ts_ff;
                     end
                  end
                  CMD_ACK_CANCEL: begin
                     if (rd_ff.state != OS_FILLED) begin
                        wdata.state = OS_CANCELLED;
                        wr_en       = lookup_en;
                     end
                  end
                  default: begin
                     // query
                     res.out_price = rd_ff.price;
                     res.out_qty   = rd_ff.qty;
                     res.out_side  = rd_ff.side;
                  end
               endcase
               res.order_state  = wdata.state;
               res.filled_total = wdata.filled;
            end
         end
         default: begin
            // unused command codes: no change, id echoed
            res.status = STAT_OK;
         end
      endcase
   end

   // lookup registers: result record, fill flags, product sum, id counter
   always_ff @(posedge clock) begin
      if (lookup_en) begin
         wk_ff        <= res;
         do_fill_ff   <= do_fill;
         fill_side_ff <= rd_ff.side;
         prod_ff      <= prod_lo_ff + {prod_hi_ff, {QTY_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff <= '0;
      end else if (lookup_en && nid_inc) begin
         next_id_ff <= next_id_ff + 1'b1;
      end
   end

   // ---------------- finish: position, cash, result register ----------------
   always_comb begin
      pos_in  = pos_ff;
      cash_in = cash_ff;
      if (do_fill_ff) begin
         if (!fill_side_ff) begin
            pos_in  = pos_ff + WORD_W'(qty_ff);
            cash_in = cash_ff - prod_ff;
         end else begin
            pos_in  = pos_ff - WORD_W'(qty_ff);
            cash_in = cash_ff + prod_ff;
         end
      end
      rsp_in              = wk_ff;
      rsp_in.holdings_now = pos_in;
      rsp_in.cash_now     = cash_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         cash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish_go) begin
            pos_ff       <= pos_in;
            cash_ff      <= cash_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_ff <= rsp_in;
      end
   end

   // ---------------- ports ----------------
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_result_id     = rsp_ff.result_id;
   assign rsp_order_state   = rsp_ff.order_state;
   assign rsp_send_kind     = rsp_ff.send_kind;
   assign rsp_out_timestamp = rsp_ff.out_timestamp;
   assign rsp_out_price     = rsp_ff.out_price;
   assign rsp_out_qty       = rsp_ff.out_qty;
   assign rsp_out_side      = rsp_ff.out_side;
   assign rsp_filled_total  = rsp_ff.filled_total;
   assign rsp_risk_echo     = rsp_ff.risk_echo;
   assign rsp_holdings_now  = rsp_ff.holdings_now;
   assign rsp_cash_now      = rsp_ff.cash_now;

   // ---------------- assertions ----------------
   // an accepted item always goes to the lookup cycle
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == FSM_LOOKUP)
      else $error("accepted item did not enter lookup");

   // the id counter never passes the table size
   a_nid_bound: assert property (@(posedge clock) disable iff (reset)
      next_id_ff <= NID_W'(TABLE_DEPTH))
      else $error("order id counter beyond table size");

   // cash moves only on the finish cycle of an executed fill
   a_cash_fill: assert property (@(posedge clock) disable iff (reset)
      (cash_ff != $past(cash_ff)) |-> $past(finish_go && do_fill_ff))
      else $error("cash changed without a fill");

   // a result is loaded only into a free output register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !finish_go)
      else $error("result register overwritten while stalled");

endmodule
